>>> sv/adivls_pkg.sv
// types, constants and micro-op programs for the adi vorticity line solver
// used by every module of the block except adivls_ram; no dependencies
package adivls_pkg;

    localparam int VALUE_BITS      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int GAIN_BITS       = 31;
    localparam int INDEX_BITS      = 6;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int LINE_POINTS_DEF = 64;
    localparam int DIV_STEPS       = VALUE_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS    = $clog2(DIV_STEPS);
    localparam int PC_BITS         = 5;
    localparam int FLAG_BITS       = 2;

    localparam logic signed [VALUE_BITS-1:0] ONE_Q = VALUE_BITS'(1 << FRAC_BITS);
    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // forward and back-substitution program layout
    localparam logic [PC_BITS-1:0] PC_PIVOT_CHECK = 5'd15;
    localparam logic [PC_BITS-1:0] PC_ZERO_FIRST  = 5'd16;
    localparam logic [PC_BITS-1:0] PC_ZERO_LAST   = 5'd17;
    localparam logic [PC_BITS-1:0] PC_DIV_FIRST   = 5'd18;
    localparam logic [PC_BITS-1:0] PC_DIV_LAST    = 5'd23;
    localparam logic [PC_BITS-1:0] PC_BACK_LAST   = 5'd2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SWEEP_AXIS,
        CFG_CONV_GAIN_X,
        CFG_DIFF_GAIN_X,
        CFG_CONV_GAIN_Y,
        CFG_DIFF_GAIN_Y
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_SAT,
        STAT_PIVOT
    } status_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] vort_here;
        logic signed [VALUE_BITS-1:0] vort_cross_before;
        logic signed [VALUE_BITS-1:0] vort_cross_after;
        logic signed [VALUE_BITS-1:0] vel_along;
        logic signed [VALUE_BITS-1:0] vel_cross;
        logic                         is_last;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]        point_index;
        logic signed [VALUE_BITS-1:0] vort_new;
        logic [1:0]                   status;
        logic                         last_result;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [4:0] {
        O_ZERO, O_ONE, O_W, O_WB, O_WA, O_VA, O_VC,
        O_CGA, O_DGA, O_CGC, O_DGC,
        O_T, O_RA, O_RB, O_D, O_TC, O_X, O_Y,
        O_LB, O_MPIV, O_MRHS, O_MUP
    } opnd_t;

    typedef enum logic [3:0] {
        D_T, D_RA, D_RB, D_RC, D_TC, D_D, D_X, D_Y, D_P, D_Q, D_W
    } dst_t;

    typedef struct packed {
        op_t   op;
        opnd_t a;
        opnd_t b;
        dst_t  dst;
    } uop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_FWD_WR,
        ST_BK_RD,
        ST_BK_RUN,
        ST_BK_EMIT
    } state_t;

    typedef struct packed {
        logic                  go;
        uop_t                  uop;
        logic                  clr_sat;
        logic                  load_item;
        logic                  load_lb;
        logic                  ram_rd;
        logic                  ram_wr;
        logic                  pz_flag;
        logic                  emit;
        logic [INDEX_BITS-1:0] index;
        logic                  last;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic piv_zero;
        logic out_free;
    } stat_t;

    function automatic uop_t mk(input op_t op, input opnd_t a, input opnd_t b,
                                input dst_t dst);
        uop_t u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.dst = dst;
        return u;
    endfunction

    // one interior point: build the row, then one elimination step
    function automatic uop_t fwd_prog(input logic [PC_BITS-1:0] pc, input logic first);
        opnd_t cp;
        opnd_t pp;
        opnd_t qp;
        uop_t  u;
        cp = first ? O_ZERO : O_MUP;
        pp = first ? O_ONE  : O_MPIV;
        qp = first ? O_LB   : O_MRHS;
        case (pc)
            5'd0:    u = mk(OP_MUL, O_VA,   O_CGA,  D_T);
            5'd1:    u = mk(OP_SUB, O_ZERO, O_T,    D_X);
            5'd2:    u = mk(OP_SUB, O_X,    O_DGA,  D_RA);
            5'd3:    u = mk(OP_ADD, O_DGA,  O_DGA,  D_X);
            5'd4:    u = mk(OP_ADD, O_ONE,  O_X,    D_RB);
            5'd5:    u = mk(OP_SUB, O_T,    O_DGA,  D_RC);
            5'd6:    u = mk(OP_MUL, O_VC,   O_CGC,  D_TC);
            5'd7:    u = mk(OP_ADD, O_DGC,  O_DGC,  D_X);
            5'd8:    u = mk(OP_SUB, O_ONE,  O_X,    D_X);
            5'd9:    u = mk(OP_MUL, O_W,    O_X,    D_D);
            5'd10:   u = mk(OP_ADD, O_TC,   O_DGC,  D_Y);
            5'd11:   u = mk(OP_MUL, O_WB,   O_Y,    D_Y);
            5'd12:   u = mk(OP_ADD, O_D,    O_Y,    D_D);
            5'd13:   u = mk(OP_SUB, O_DGC,  O_TC,   D_Y);
            5'd14:   u = mk(OP_MUL, O_WA,   O_Y,    D_Y);
            5'd15:   u = mk(OP_ADD, O_D,    O_Y,    D_D);
            // zero pivot: quotient terms dropped
            5'd16:   u = mk(OP_ADD, O_RB,   O_ZERO, D_P);
            5'd17:   u = mk(OP_ADD, O_D,    O_ZERO, D_Q);
            5'd18:   u = mk(OP_MUL, O_RA,   cp,     D_X);
            5'd19:   u = mk(OP_DIV, O_X,    pp,     D_X);
            5'd20:   u = mk(OP_SUB, O_RB,   O_X,    D_P);
            5'd21:   u = mk(OP_MUL, qp,     O_RA,   D_X);
            5'd22:   u = mk(OP_DIV, O_X,    pp,     D_X);
            5'd23:   u = mk(OP_SUB, O_D,    O_X,    D_Q);
            default: u = mk(OP_ADD, O_ZERO, O_ZERO, D_X);
        endcase
        return u;
    endfunction

    // one back-substitution point, w holds the value of the point above
    function automatic uop_t bk_prog(input logic [PC_BITS-1:0] pc, input logic pz);
        uop_t u;
        case (pc)
            5'd0:    u = mk(OP_MUL, O_MUP,  O_W,    D_X);
            5'd1:    u = mk(OP_SUB, O_MRHS, O_X,    D_X);
            5'd2:    u = pz ? mk(OP_ADD, O_ZERO, O_ZERO, D_W)
                            : mk(OP_DIV, O_X,    O_MPIV, D_W);
            default: u = mk(OP_ADD, O_ZERO, O_ZERO, D_X);
        endcase
        return u;
    endfunction

endpackage

>>> sv/adi_vorticity_line_solver_core.sv
// top level of the adi vorticity line solver: thomas elimination over one grid line
// depends on adivls_pkg, adivls_ctrl, adivls_dpath, adivls_ram
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  item     | item_valid / item_stall    | item (in_item_t), one line point
//  result   | result_valid / result_stall| result (out_item_t), one interior point
//  cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data (five registers)
//
// an interior point runs 16 row-building micro-ops and, unless the previous pivot is zero, two
// quotients, each quotient 48 steps of the shared radix-2 divider
// boundary points run no micro-ops; the closing item runs back-substitution with one
// divide per result unless its pivot is zero, emitted from the top point down
// reset clears the controller and loads the default gains; the line store needs no clearing
// item_stall is high from the cycle after a point is taken until its work ends;
// result_stall holds the current beat and pauses back-substitution
module adi_vorticity_line_solver_core #(
    parameter int LINE_POINTS = adivls_pkg::LINE_POINTS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  adivls_pkg::in_item_t                  item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output adivls_pkg::out_item_t                 result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [adivls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [adivls_pkg::VALUE_BITS-1:0]     cfg_data
);
    import adivls_pkg::*;

    cmd_t                          cmd;
    stat_t                         stat;
    logic [$clog2(LINE_POINTS)-1:0] ram_addr;

    assign cfg_ready = 1'b1;

    adivls_ctrl #(
        .LINE_POINTS (LINE_POINTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_last  (item.is_last),
        .item_stall (item_stall),
        .cmd        (cmd),
        .ram_addr   (ram_addr),
        .stat       (stat)
    );

    adivls_dpath #(
        .LINE_POINTS (LINE_POINTS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .ram_addr     (ram_addr),
        .item         (item),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // the closing beat of a line is always point 1
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_result |-> result.point_index == INDEX_BITS'(1))
        else $error("last beat not at point 1");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status != 2'd3)
        else $error("undefined status code");

    // nothing follows the closing beat until a new line is run
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result.last_result |=> !result_valid)
        else $error("beat after closing beat");

    // no item is taken while back-substitution still owes beats
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_result |-> item_stall)
        else $error("item taken during back-substitution");

endmodule

>>> sv/adivls_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module adivls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/adivls_dpath.sv
// datapath: operand registers, saturating add/sub, multiplier, radix-2 divider,
// line store and result register; depends on adivls_pkg and adivls_ram
module adivls_dpath #(
    parameter int LINE_POINTS = adivls_pkg::LINE_POINTS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  adivls_pkg::cmd_t                       cmd,
    input  logic [$clog2(LINE_POINTS)-1:0]         ram_addr,
    input  adivls_pkg::in_item_t                   item,
    input  logic                                   cfg_we,
    input  logic [adivls_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [adivls_pkg::VALUE_BITS-1:0]      cfg_data,
    output adivls_pkg::stat_t                      stat,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output adivls_pkg::out_item_t                  result
);
    import adivls_pkg::*;

    localparam int AW = $clog2(LINE_POINTS);
    localparam int EW = 3 * VALUE_BITS + FLAG_BITS;

    typedef logic signed [VALUE_BITS-1:0] val_t;

    // configuration
    logic                 sweep_reg;
    logic [GAIN_BITS-1:0] cgx_reg, dgx_reg, cgy_reg, dgy_reg;

    val_t w_reg, wb_reg, wa_reg, va_reg, vc_reg, lb_reg;
    val_t t_reg, ra_reg, rb_reg, rc_reg, tc_reg, d_reg, x_reg, y_reg, p_reg, q_reg;
    logic sat_reg;

    // multiplier
    logic signed [2*VALUE_BITS-1:0] prod_reg;
    logic                           mul_phase_reg;
    dst_t                           pend_dst_reg;

    // divider
    logic                    div_busy_reg, div_fin_reg, div_neg_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;
    logic [VALUE_BITS-1:0]   rem_reg, dsr_reg;
    logic [DIV_STEPS-1:0]    quo_reg;

    logic done_reg;

    logic                   out_valid_reg;
    out_item_t              out_reg;

    logic [EW-1:0] ram_wdata, ram_rdata;
    logic [FLAG_BITS-1:0] m_flag;
    val_t m_piv, m_rhs, m_up;

    val_t src [32];
    val_t opa, opb;

    logic                   wb_en, wb_sat;
    dst_t                   wb_dst;
    val_t                   wb_val;
    logic signed [VALUE_BITS:0] sum;
    logic signed [2*VALUE_BITS-1:0] rnd;
    logic [VALUE_BITS:0]     rem_sh;
    logic [VALUE_BITS+1:0]   diff;
    logic [FLAG_BITS-1:0]    fl;

    assign m_flag = ram_rdata[EW-1 -: FLAG_BITS];
    assign m_piv  = ram_rdata[3*VALUE_BITS-1 -: VALUE_BITS];
    assign m_rhs  = ram_rdata[2*VALUE_BITS-1 -: VALUE_BITS];
    assign m_up   = ram_rdata[VALUE_BITS-1:0];

    assign ram_wdata = {cmd.pz_flag, sat_reg, p_reg, q_reg, rc_reg};

    adivls_ram #(
        .WIDTH (EW),
        .DEPTH (LINE_POINTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.ram_wr),
        .wr_addr (ram_addr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.ram_rd),
        .rd_addr (ram_addr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        src          = '{default: '0};
        src[O_ZERO]  = '0;
        src[O_ONE]   = ONE_Q;
        src[O_W]     = w_reg;
        src[O_WB]    = wb_reg;
        src[O_WA]    = wa_reg;
        src[O_VA]    = va_reg;
        src[O_VC]    = vc_reg;
        src[O_CGA]   = {1'b0, sweep_reg ? cgy_reg : cgx_reg};
        src[O_DGA]   = {1'b0, sweep_reg ? dgy_reg : dgx_reg};
        src[O_CGC]   = {1'b0, sweep_reg ? cgx_reg : cgy_reg};
        src[O_DGC]   = {1'b0, sweep_reg ? dgx_reg : dgy_reg};
        src[O_T]     = t_reg;
        src[O_RA]    = ra_reg;
        src[O_RB]    = rb_reg;
        src[O_D]     = d_reg;
        src[O_TC]    = tc_reg;
        src[O_X]     = x_reg;
        src[O_Y]     = y_reg;
        src[O_LB]    = lb_reg;
        src[O_MPIV]  = m_piv;
        src[O_MRHS]  = m_rhs;
        src[O_MUP]   = m_up;
    end

    assign opa = src[cmd.uop.a];
    assign opb = src[cmd.uop.b];

    // divider step
    assign rem_sh = {rem_reg, quo_reg[DIV_STEPS-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};

    // result write-back, one source at a time
    always_comb
    begin
        wb_en  = 1'b0;
        wb_sat = 1'b0;
        wb_dst = cmd.uop.dst;
        wb_val = '0;
        sum    = '0;
        rnd    = (prod_reg + (2*VALUE_BITS)'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
        if (cmd.go && (cmd.uop.op == OP_ADD || cmd.uop.op == OP_SUB))
        begin
            if (cmd.uop.op == OP_ADD)
            begin
                sum = {opa[VALUE_BITS-1], opa} + {opb[VALUE_BITS-1], opb};
            end
            else
            begin
                sum = {opa[VALUE_BITS-1], opa} - {opb[VALUE_BITS-1], opb};
            end
            wb_en = 1'b1;
            if (sum[VALUE_BITS] != sum[VALUE_BITS-1])
            begin
                wb_sat = 1'b1;
                wb_val = sum[VALUE_BITS] ? VAL_MIN : VAL_MAX;
            end
            else
            begin
                wb_val = sum[VALUE_BITS-1:0];
            end
        end
        else if (mul_phase_reg)
        begin
            wb_en  = 1'b1;
            wb_dst = pend_dst_reg;
            if (rnd > (2*VALUE_BITS)'(VAL_MAX))
            begin
                wb_sat = 1'b1;
                wb_val = VAL_MAX;
            end
            else if (rnd < (2*VALUE_BITS)'(VAL_MIN))
            begin
                wb_sat = 1'b1;
                wb_val = VAL_MIN;
            end
            else
            begin
                wb_val = rnd[VALUE_BITS-1:0];
            end
        end
        else if (div_fin_reg)
        begin
            wb_en  = 1'b1;
            wb_dst = pend_dst_reg;
            if (div_neg_reg)
            begin
                if (quo_reg > DIV_STEPS'({1'b1, {(VALUE_BITS-1){1'b0}}}))
                begin
                    wb_sat = 1'b1;
                    wb_val = VAL_MIN;
                end
                else
                begin
                    wb_val = VALUE_BITS'(0) - quo_reg[VALUE_BITS-1:0];
                end
            end
            else if (quo_reg > DIV_STEPS'(VAL_MAX))
            begin
                wb_sat = 1'b1;
                wb_val = VAL_MAX;
            end
            else
            begin
                wb_val = quo_reg[VALUE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b0;
            cgx_reg       <= GAIN_BITS'(3277);
            dgx_reg       <= GAIN_BITS'(819);
            cgy_reg       <= GAIN_BITS'(3277);
            dgy_reg       <= GAIN_BITS'(819);
            lb_reg        <= '0;
            sat_reg       <= 1'b0;
            mul_phase_reg <= 1'b0;
            div_busy_reg  <= 1'b0;
            div_fin_reg   <= 1'b0;
            div_cnt_reg   <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SWEEP_AXIS:  sweep_reg <= cfg_data[0];
                    CFG_CONV_GAIN_X: cgx_reg   <= cfg_data[GAIN_BITS-1:0];
                    CFG_DIFF_GAIN_X: dgx_reg   <= cfg_data[GAIN_BITS-1:0];
                    CFG_CONV_GAIN_Y: cgy_reg   <= cfg_data[GAIN_BITS-1:0];
                    CFG_DIFF_GAIN_Y: dgy_reg   <= cfg_data[GAIN_BITS-1:0];
                    default:         ;
                endcase
            end

            if (cmd.load_lb)
            begin
                lb_reg <= item.vort_here;
            end

            if (cmd.clr_sat)
            begin
                sat_reg <= 1'b0;
            end
            else if (wb_sat)
            begin
                sat_reg <= 1'b1;
            end

            mul_phase_reg <= cmd.go && cmd.uop.op == OP_MUL;
            done_reg      <= wb_en;

            div_fin_reg <= 1'b0;
            if (cmd.go && cmd.uop.op == OP_DIV)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_BITS'(DIV_STEPS-1))
                begin
                    div_busy_reg <= 1'b0;
                    div_fin_reg  <= 1'b1;
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            w_reg  <= item.vort_here;
            wb_reg <= item.vort_cross_before;
            wa_reg <= item.vort_cross_after;
            va_reg <= item.vel_along;
            vc_reg <= item.vel_cross;
        end
        else if (wb_en && wb_dst == D_W)
        begin
            w_reg <= wb_val;
        end

        if (wb_en)
        begin
            case (wb_dst)
                D_T:     t_reg  <= wb_val;
                D_RA:    ra_reg <= wb_val;
                D_RB:    rb_reg <= wb_val;
                D_RC:    rc_reg <= wb_val;
                D_TC:    tc_reg <= wb_val;
                D_D:     d_reg  <= wb_val;
                D_X:     x_reg  <= wb_val;
                D_Y:     y_reg  <= wb_val;
                D_P:     p_reg  <= wb_val;
                D_Q:     q_reg  <= wb_val;
                default: ;
            endcase
        end

        if (cmd.go)
        begin
            pend_dst_reg <= cmd.uop.dst;
        end
        if (cmd.go && cmd.uop.op == OP_MUL)
        begin
            prod_reg <= opa * opb;
        end

        if (cmd.go && cmd.uop.op == OP_DIV)
        begin
            // magnitudes; the sign is put back at the end, truncating toward zero
            rem_reg     <= '0;
            quo_reg     <= {(opa[VALUE_BITS-1] ? VALUE_BITS'(0) - opa : opa),
                            {FRAC_BITS{1'b0}}};
            dsr_reg     <= opb[VALUE_BITS-1] ? VALUE_BITS'(0) - opb : opb;
            div_neg_reg <= opa[VALUE_BITS-1] ^ opb[VALUE_BITS-1];
        end
        else if (div_busy_reg)
        begin
            rem_reg <= diff[VALUE_BITS+1] ? rem_sh[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
            quo_reg <= {quo_reg[DIV_STEPS-2:0], ~diff[VALUE_BITS+1]};
        end

        if (cmd.emit)
        begin
            out_reg.point_index <= cmd.index;
            out_reg.vort_new    <= w_reg;
            out_reg.last_result <= cmd.last;
            if (fl[1])
            begin
                out_reg.status <= STAT_PIVOT;
            end
            else if (fl[0])
            begin
                out_reg.status <= STAT_SAT;
            end
            else
            begin
                out_reg.status <= STAT_OK;
            end
        end
    end

    assign fl = m_flag | {cmd.pz_flag, sat_reg};

    assign stat.done     = done_reg;
    assign stat.piv_zero = (m_piv == '0);
    assign stat.out_free = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

>>> sv/adivls_ctrl.sv
// controller: line position, forward and back-substitution sequencing,
// micro-op issue and result beats; depends on adivls_pkg
module adivls_ctrl #(
    parameter int LINE_POINTS = adivls_pkg::LINE_POINTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic                           item_last,
    output logic                           item_stall,
    output adivls_pkg::cmd_t               cmd,
    output logic [$clog2(LINE_POINTS)-1:0] ram_addr,
    input  adivls_pkg::stat_t              stat
);
    import adivls_pkg::*;

    localparam int CW = $clog2(LINE_POINTS);

    state_t              state_reg, state_next;
    logic [PC_BITS-1:0]  pc_reg, pc_next;
    logic                issued_reg, issued_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                first_reg, first_next;
    logic                pz_reg, pz_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pc_reg     <= '0;
            issued_reg <= 1'b0;
            count_reg  <= '0;
            idx_reg    <= '0;
            first_reg  <= 1'b0;
            pz_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            issued_reg <= issued_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            first_reg  <= first_next;
            pz_reg     <= pz_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        issued_next = issued_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        first_next  = first_reg;
        pz_next     = pz_reg;
        cmd         = '0;
        cmd.uop     = fwd_prog(pc_reg, first_reg);
        cmd.pz_flag = pz_reg;
        cmd.index   = INDEX_BITS'(idx_reg);
        cmd.last    = (idx_reg == CW'(1));
        ram_addr    = idx_reg;
        item_stall  = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                ram_addr = count_reg - 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (item_last)
                    begin
                        count_next = '0;
                        if (count_reg >= CW'(2))
                        begin
                            idx_next   = count_reg - 1'b1;
                            state_next = ST_BK_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        cmd.load_lb = 1'b1;
                        count_next  = CW'(1);
                    end
                    else if (count_reg <= CW'(LINE_POINTS-2))
                    begin
                        cmd.ram_rd  = 1'b1;
                        cmd.clr_sat = 1'b1;
                        first_next  = (count_reg == CW'(1));
                        idx_next    = count_reg;
                        pc_next     = '0;
                        pz_next     = 1'b0;
                        issued_next = 1'b0;
                        state_next  = ST_FWD;
                    end
                end
            end

            ST_FWD:
            begin
                cmd.uop = fwd_prog(pc_reg, first_reg);
                if (!issued_reg)
                begin
                    cmd.go      = 1'b1;
                    issued_next = 1'b1;
                end
                else if (stat.done)
                begin
                    issued_next = 1'b0;
                    if (pc_reg == PC_PIVOT_CHECK)
                    begin
                        pz_next = !first_reg && stat.piv_zero;
                        pc_next = (!first_reg && stat.piv_zero) ? PC_ZERO_FIRST : PC_DIV_FIRST;
                    end
                    else if (pc_reg == PC_ZERO_LAST || pc_reg == PC_DIV_LAST)
                    begin
                        state_next = ST_FWD_WR;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end

            ST_FWD_WR:
            begin
                cmd.ram_wr = 1'b1;
                count_next = idx_reg + 1'b1;
                state_next = ST_IDLE;
            end

            ST_BK_RD:
            begin
                cmd.ram_rd  = 1'b1;
                cmd.clr_sat = 1'b1;
                pc_next     = '0;
                issued_next = 1'b0;
                state_next  = ST_BK_RUN;
            end

            ST_BK_RUN:
            begin
                cmd.uop = bk_prog(pc_reg, stat.piv_zero);
                if (!issued_reg)
                begin
                    cmd.go      = 1'b1;
                    issued_next = 1'b1;
                end
                else if (stat.done)
                begin
                    issued_next = 1'b0;
                    if (pc_reg == PC_BACK_LAST)
                    begin
                        pz_next    = stat.piv_zero;
                        state_next = ST_BK_EMIT;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end

            ST_BK_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (idx_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_BK_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> verif/tb.sv
// self-checking testbench for adi_vorticity_line_solver_core: thomas line solve
// keeps its own line solver model and checks every result beat; depends on adivls_pkg
`timescale 1ns / 100ps

module tb;
    import adivls_pkg::*;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam longint ONE_V = 64'sd65536;
    localparam int MAX_POS = LINE_POINTS_DEF - 2;
    localparam int SETTLE = 400;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    in_item_t item;
    logic result_valid;
    logic result_stall;
    out_item_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [VALUE_BITS-1:0] cfg_data;

    adi_vorticity_line_solver_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // solver model state
    logic         axis_y;
    logic [30:0]  cg_x, dg_x, cg_y, dg_y;
    longint       pivots [LINE_POINTS_DEF];
    longint       rhs_vals [LINE_POINTS_DEF];
    longint       uppers [LINE_POINTS_DEF];
    logic [1:0]   row_flags [LINE_POINTS_DEF];
    int           line_pos;
    longint       left_val;
    bit           clipped;

    out_item_t    vort_q[$];
    int           send_idle_pct;
    int           stall_pct;
    int           hold_req;
    int           mismatches;
    int           beats_checked;
    int           lines_sent;
    int           pivot_beats;
    int           sat_beats;

    always #10 clk = ~clk;

    function automatic longint clip(longint x);
        if (x > VMAX) begin clipped = 1; return VMAX; end
        if (x < VMIN) begin clipped = 1; return VMIN; end
        return x;
    endfunction

    function automatic longint qadd(longint a, longint b);
        return clip(a + b);
    endfunction

    function automatic longint qsub(longint a, longint b);
        return clip(a - b);
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b + 64'sd32768;
        return clip(p >>> 16);
    endfunction

    function automatic longint qdiv(longint n, longint d);
        if (d == 0)
            return 0;
        return clip((n * 64'sd65536) / d);
    endfunction

    task automatic solve_point(input in_item_t it);
        longint w, wb, wa, va, vc, cga, dga, cgc, dgc;
        longint t, ra, rb, rc, tc, rd, pp, cp, qp, p, q, next, num, val;
        logic [1:0] fl;
        int idx;
        out_item_t o;
        idx = line_pos;
        w = longint'($signed(it.vort_here));
        if (it.is_last) begin
            line_pos = 0;
            if (idx < 2)
                return;
            next = w;
            for (int i = idx - 1; i >= 1; i--) begin
                fl = row_flags[i];
                clipped = 0;
                num = qsub(rhs_vals[i], qmul(uppers[i], next));
                if (pivots[i] == 0) begin
                    val = 0;
                    fl[1] = 1'b1;
                end
                else
                    val = qdiv(num, pivots[i]);
                if (clipped)
                    fl[0] = 1'b1;
                next = val;
                o.point_index = i[INDEX_BITS-1:0];
                o.vort_new = val[31:0];
                o.status = fl[1] ? STAT_PIVOT : (fl[0] ? STAT_SAT : STAT_OK);
                o.last_result = (i == 1);
                vort_q.push_back(o);
            end
            return;
        end
        if (idx == 0) begin
            left_val = w;
            line_pos = 1;
            return;
        end
        if (idx > MAX_POS)
            return;
        if (axis_y) begin
            cga = cg_y; dga = dg_y; cgc = cg_x; dgc = dg_x;
        end
        else begin
            cga = cg_x; dga = dg_x; cgc = cg_y; dgc = dg_y;
        end
        wb = longint'($signed(it.vort_cross_before));
        wa = longint'($signed(it.vort_cross_after));
        va = longint'($signed(it.vel_along));
        vc = longint'($signed(it.vel_cross));
        fl = 2'b00;
        clipped = 0;
        t = qmul(va, cga);
        ra = qsub(qsub(0, t), dga);
        rb = qadd(ONE_V, qadd(dga, dga));
        rc = qsub(t, dga);
        tc = qmul(vc, cgc);
        rd = qadd(qadd(qmul(w, qsub(ONE_V, qadd(dgc, dgc))), qmul(wb, qadd(tc, dgc))),
                  qmul(wa, qsub(dgc, tc)));
        if (idx == 1) begin
            pp = ONE_V; cp = 0; qp = left_val;
        end
        else begin
            pp = pivots[idx-1]; cp = uppers[idx-1]; qp = rhs_vals[idx-1];
        end
        if (pp == 0) begin
            fl[1] = 1'b1;
            p = rb;
            q = rd;
        end
        else begin
            p = qsub(rb, qdiv(qmul(ra, cp), pp));
            q = qsub(rd, qdiv(qmul(qp, ra), pp));
        end
        if (clipped)
            fl[0] = 1'b1;
        pivots[idx] = p;
        rhs_vals[idx] = q;
        uppers[idx] = rc;
        row_flags[idx] = fl;
        line_pos = idx + 1;
    endtask

    // result beats are compared against the oldest predicted point
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall) begin
            if (vort_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: idx %0d vort %h", result.point_index,
                             result.vort_new);
            end
            else begin
                beats_checked++;
                if (vort_q[0].status == STAT_PIVOT) pivot_beats++;
                if (vort_q[0].status == STAT_SAT) sat_beats++;
                if (result.point_index !== vort_q[0].point_index ||
                    result.vort_new !== vort_q[0].vort_new ||
                    result.status !== vort_q[0].status ||
                    result.last_result !== vort_q[0].last_result) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                                 vort_q[0].point_index, vort_q[0].vort_new, vort_q[0].status,
                                 vort_q[0].last_result, result.point_index, result.vort_new,
                                 result.status, result.last_result);
                end
                void'(vort_q.pop_front());
            end
        end
    end

    // receiver stalls, with a counted hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        int hold_left;
        if (!rst_n) begin
            result_stall <= 1'b0;
            hold_left = 0;
        end
        else begin
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
                hold_left--;
            result_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_point(input in_item_t it);
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        solve_point(it);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_val(input int mode);
        case (mode)
            0: return 32'($urandom_range(0, 524288)) - 32'd262144;
            1: return $urandom;
            default: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    function automatic in_item_t mk_point(input int mode, input logic closing);
        in_item_t it;
        it.vort_here = rand_val(mode);
        it.vort_cross_before = rand_val(mode);
        it.vort_cross_after = rand_val(mode);
        it.vel_along = rand_val(mode);
        it.vel_cross = rand_val(mode);
        it.is_last = closing;
        return it;
    endfunction

    // npts points, the last one closing the line
    task automatic send_line(input int npts, input int mode);
        for (int i = 0; i < npts; i++)
            send_point(mk_point(mode, i == npts - 1));
        lines_sent++;
    endtask

    task automatic drain;
        item_valid <= 1'b0;
        while (vort_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SWEEP_AXIS:  axis_y = data[0];
            CFG_CONV_GAIN_X: cg_x = data[30:0];
            CFG_DIFF_GAIN_X: dg_x = data[30:0];
            CFG_CONV_GAIN_Y: cg_y = data[30:0];
            default:         dg_y = data[30:0];
        endcase
        @(posedge clk);
    endtask

    task automatic write_gains(input logic [31:0] axis, input logic [31:0] cx,
                               input logic [31:0] dx, input logic [31:0] cy,
                               input logic [31:0] dy);
        write_reg(CFG_SWEEP_AXIS, axis);
        write_reg(CFG_CONV_GAIN_X, cx);
        write_reg(CFG_DIFF_GAIN_X, dx);
        write_reg(CFG_CONV_GAIN_Y, cy);
        write_reg(CFG_DIFF_GAIN_Y, dy);
    endtask

    task automatic test_short_lines;
        send_line(1, 0);
        send_line(2, 1);
        send_line(3, 0);
        drain();
    endtask

    task automatic test_field_extremes;
        in_item_t it;
        it = '0;
        send_point(it);
        it = '1;
        it.is_last = 1'b0;
        send_point(it);
        send_point(mk_point(2, 1'b0));
        send_point(mk_point(2, 1'b0));
        send_point(mk_point(2, 1'b1));
        lines_sent++;
        drain();
        write_gains(32'hffff_fffe, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_ffff);
        send_line(4, 1);
        send_line(4, 2);
        drain();
        write_gains(32'd1, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
        send_line(4, 1);
        drain();
    endtask

    // along gain of one and no diffusion: rows 1 and 2 cancel to a zero pivot
    task automatic test_zero_pivot;
        in_item_t it;
        write_gains(32'd0, 32'd65536, 32'd0, 32'd65536, 32'd0);
        it = mk_point(0, 1'b0);
        send_point(it);
        it.vel_along = 32'd65536;
        send_point(it);
        it.vel_along = -32'sd65536;
        send_point(it);
        it.vel_along = 32'd4096;
        send_point(it);
        it.is_last = 1'b1;
        send_point(it);
        lines_sent++;
        drain();
    endtask

    task automatic test_overlong_line;
        write_gains(32'd1, 32'd3277, 32'd819, 32'd6554, 32'd1638);
        send_line(LINE_POINTS_DEF + 2, 0);
        drain();
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = 1500;
        send_line(8, 0);
        send_line(6, 0);
        drain();
    endtask

    task automatic test_random(input int idle, input int stall, input int nitems);
        int sent;
        int npts;
        send_idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < nitems) begin
            npts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
            send_line(npts, ($urandom_range(0, 5) == 0) ? 1 : 0);
            sent += npts;
        end
        drain();
        write_gains($urandom_range(0, 1), $urandom_range(0, 16384), $urandom_range(0, 4096),
                    $urandom_range(0, 16384), $urandom_range(0, 4096));
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        beats_checked = 0;
        lines_sent = 0;
        pivot_beats = 0;
        sat_beats = 0;
        axis_y = 1'b0;
        cg_x = 31'd3277; dg_x = 31'd819; cg_y = 31'd3277; dg_y = 31'd819;
        line_pos = 0;
        left_val = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_lines();
        test_field_extremes();
        test_zero_pivot();
        test_overlong_line();
        test_backpressure();
        test_random(0, 0, 40);
        test_random(79, 0, 40);
        test_random(0, 79, 40);
        test_random(32, 32, 40);
        test_random(0, 0, 20);

        drain();
        $display("covered %0d lines, %0d result beats checked (%0d zero pivot, %0d saturated)",
                 lines_sent, beats_checked, pivot_beats, sat_beats);
        $display("short, overlong, zero-pivot and held-off lines under several gain settings");
        if (mismatches == 0 && vort_q.size() == 0)
            $display("PASS adi_vorticity_line_solver_core");
        else
            $display("FAIL adi_vorticity_line_solver_core");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("FAIL adi_vorticity_line_solver_core");
        $finish;
    end

endmodule

>>> files.f
sv/adivls_pkg.sv
sv/adivls_ram.sv
sv/adivls_dpath.sv
sv/adivls_ctrl.sv
sv/adi_vorticity_line_solver_core.sv
verif/tb.sv
